// ===== hw/rtl/scel_pkg.sv =====
// Shared types and constants for the square channel envelope/length controller.
package scel_pkg;

    typedef enum logic [0:0] {
        CMD_WRITE = 1'b0,
        CMD_TICK  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        REG_LEN_DUTY = 2'd0,
        REG_ENVELOPE = 2'd1,
        REG_FREQ_LO  = 2'd2,
        REG_FREQ_HI  = 2'd3
    } reg_sel_t;

    localparam int ELAPSED_W = 24;
    localparam int LIMIT_W   = 32;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
    localparam logic [7:0]           ENV_DIR_MASK = 8'h08;
    localparam logic [3:0]           VOL_MAX      = 4'd15;
    localparam logic [6:0]           LENGTH_SPAN  = 7'd64;

endpackage

// ===== hw/rtl/square_channel_envelope_length.sv =====
// Square channel control: envelope, length timer, period and duty registers per beat.
// Each input beat is a register write or a time tick; each gives one result beat
// with the channel state after it. One beat is accepted per cycle unless a stalled
// result holds the flow. A taken beat is held in the input register; the state
// register, which also drives the result ports, then loads from it unless a waiting
// result is stalled. A tick compares the saturating envelope and length counters
// against thresholds derived from CYCLES_PER_SECOND.
module square_channel_envelope_length
    import scel_pkg::*;
#(
    parameter int CYCLES_PER_SECOND = 4213440
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [1:0]  s_reg_select,
    input  logic [7:0]  s_write_data,
    input  logic [15:0] s_tick_cycles,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_channel_on,
    output logic [3:0]  m_volume_level,
    output logic [10:0] m_period_value,
    output logic [1:0]  m_duty_code,
    output logic [7:0]  m_envelope_byte
);

    localparam logic [LIMIT_W-1:0] CPS = LIMIT_W'(CYCLES_PER_SECOND);

    logic                 in_valid_reg;
    logic                 cmd_reg;
    logic [1:0]           sel_reg;
    logic [7:0]           data_reg;
    logic [15:0]          cycles_reg;

    logic                 out_valid_reg;
    logic [5:0]           length_load_reg, length_load_next;
    logic [1:0]           duty_sel_reg, duty_sel_next;
    logic [7:0]           env_reg, env_next;
    logic [10:0]          freq_reg, freq_next;
    logic                 length_enable_reg, length_enable_next;
    logic                 active_reg, active_next;
    logic [ELAPSED_W-1:0] env_elapsed_reg, env_elapsed_next;
    logic [ELAPSED_W-1:0] len_elapsed_reg, len_elapsed_next;

    logic                 advance;
    logic [ELAPSED_W:0]   env_sum, len_sum;
    logic [ELAPSED_W-1:0] env_sat, len_sat;
    logic [LIMIT_W-1:0]   env_limit, len_limit;
    logic                 env_fire, len_expire;
    logic [2:0]           env_period;
    logic [3:0]           vol;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            cmd_reg    <= s_command;
            sel_reg    <= s_reg_select;
            data_reg   <= s_write_data;
            cycles_reg <= s_tick_cycles;
        end
    end

    assign env_period = env_reg[2:0];
    assign vol        = env_reg[7:4];
    assign env_sum    = {1'b0, env_elapsed_reg} + (ELAPSED_W + 1)'(cycles_reg);
    assign len_sum    = {1'b0, len_elapsed_reg} + (ELAPSED_W + 1)'(cycles_reg);
    assign env_sat    = env_sum[ELAPSED_W] ? ELAPSED_MAX : env_sum[ELAPSED_W-1:0];
    assign len_sat    = len_sum[ELAPSED_W] ? ELAPSED_MAX : len_sum[ELAPSED_W-1:0];
    assign env_limit  = LIMIT_W'(env_period) * CPS;
    assign len_limit  = LIMIT_W'(LENGTH_SPAN - {1'b0, length_load_reg}) * CPS;
    assign env_fire   = (LIMIT_W'({env_sat, 6'b0}) > env_limit);
    assign len_expire = length_enable_reg && (LIMIT_W'({len_sat, 8'b0}) >= len_limit);

    always_comb begin
        length_load_next   = length_load_reg;
        duty_sel_next      = duty_sel_reg;
        env_next           = env_reg;
        freq_next          = freq_reg;
        length_enable_next = length_enable_reg;
        active_next        = active_reg;
        env_elapsed_next   = env_elapsed_reg;
        len_elapsed_next   = len_elapsed_reg;
        if (cmd_t'(cmd_reg) == CMD_TICK) begin
            if (env_period != 3'd0) begin
                if (env_fire) begin
                    env_elapsed_next = '0;
                    if (env_reg[3]) begin
                        if (vol == VOL_MAX) begin
                            env_next = env_reg & ENV_DIR_MASK;
                        end else begin
                            env_next = {vol + 4'd1, env_reg[3:0]};
                        end
                    end else begin
                        if (vol == 4'd0) begin
                            env_next = env_reg & ENV_DIR_MASK;
                        end else begin
                            env_next = {vol - 4'd1, env_reg[3:0]};
                        end
                    end
                end else begin
                    env_elapsed_next = env_sat;
                end
            end
            len_elapsed_next = len_sat;
            if (len_expire) begin
                active_next = 1'b0;
            end
        end else begin
            case (reg_sel_t'(sel_reg))
                REG_LEN_DUTY: begin
                    length_load_next = data_reg[5:0];
                    duty_sel_next    = data_reg[7:6];
                end
                REG_ENVELOPE: begin
                    env_next = data_reg;
                end
                REG_FREQ_LO: begin
                    freq_next = {freq_reg[10:8], data_reg};
                end
                REG_FREQ_HI: begin
                    freq_next          = {data_reg[2:0], freq_reg[7:0]};
                    length_enable_next = data_reg[6];
                    if (data_reg[7]) begin
                        active_next      = 1'b1;
                        len_elapsed_next = '0;
                    end
                end
                default: begin
                    env_next = env_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg     <= 1'b0;
            length_load_reg   <= '0;
            duty_sel_reg      <= '0;
            env_reg           <= '0;
            freq_reg          <= '0;
            length_enable_reg <= 1'b0;
            active_reg        <= 1'b0;
            env_elapsed_reg   <= '0;
            len_elapsed_reg   <= '0;
        end else begin
            if (advance) begin
                out_valid_reg     <= 1'b1;
                length_load_reg   <= length_load_next;
                duty_sel_reg      <= duty_sel_next;
                env_reg           <= env_next;
                freq_reg          <= freq_next;
                length_enable_reg <= length_enable_next;
                active_reg        <= active_next;
                env_elapsed_reg   <= env_elapsed_next;
                len_elapsed_reg   <= len_elapsed_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_channel_on    = active_reg;
    assign m_volume_level  = env_reg[7:4];
    assign m_period_value  = freq_reg;
    assign m_duty_code     = duty_sel_reg;
    assign m_envelope_byte = env_reg;

endmodule

// ===== hw/rtl/scel_checker.sv =====
// Port-level checks for the square channel controller, bound to its top level.
module scel_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_channel_on,
    input logic [3:0]  m_volume_level,
    input logic [10:0] m_period_value,
    input logic [1:0]  m_duty_code,
    input logic [7:0]  m_envelope_byte
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    a_stall_keeps_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    a_stall_keeps_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_channel_on) && $stable(m_envelope_byte)
            && $stable(m_period_value) && $stable(m_duty_code))
        else $error("result beat changed while stalled");

    a_volume_matches_envelope: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_volume_level == m_envelope_byte[7:4])
        else $error("volume differs from envelope byte");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##2 m_valid)
        else $error("no result beat after an input beat");

endmodule

bind square_channel_envelope_length scel_checker u_scel_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_channel_on    (m_channel_on),
    .m_volume_level  (m_volume_level),
    .m_period_value  (m_period_value),
    .m_duty_code     (m_duty_code),
    .m_envelope_byte (m_envelope_byte)
);

// ===== tb/square_channel_envelope_length_test.sv =====
// Self-checking testbench for the square channel envelope/length controller.
`timescale 1ns / 1ps

module square_channel_envelope_length_test;
    import scel_pkg::*;

    localparam int CLOCK_RATE   = 4213440;
    localparam int TOTAL_BEATS  = 1650;
    localparam int HOLD_AT      = 400;
    localparam int QUIET_AT     = 600;
    localparam int CALM_AT      = 1400;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic        on;
        logic [3:0]  volume;
        logic [10:0] period;
        logic [1:0]  duty;
        logic [7:0]  env;
    } channel_state_t;

    class channel_state_board;
        logic [5:0]     len_load;
        logic [1:0]     duty;
        logic [7:0]     env;
        logic [10:0]    freq;
        logic           len_en;
        logic           on;
        logic [23:0]    env_count;
        logic [23:0]    len_count;
        channel_state_t expected_states[$];
        int             failures;

        function new();
            len_load  = '0;
            duty      = '0;
            env       = '0;
            freq      = '0;
            len_en    = 1'b0;
            on        = 1'b0;
            env_count = '0;
            len_count = '0;
            failures  = 0;
        endfunction

        function logic [23:0] sat_add(logic [23:0] a, logic [15:0] b);
            logic [24:0] sum;
            sum = {1'b0, a} + {9'd0, b};
            return (sum > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX : sum[23:0];
        endfunction

        function void step_envelope(logic [15:0] cyc);
            logic [2:0] per;
            logic [3:0] vol;
            per = env[2:0];
            if (per == 3'd0) return;
            env_count = sat_add(env_count, cyc);
            if (64'(env_count) * 64'd64 <= 64'(per) * 64'(CLOCK_RATE)) return;
            env_count = '0;
            vol = env[7:4];
            if (env[3]) begin
                if (vol == VOL_MAX) begin
                    env = env & ENV_DIR_MASK;
                    return;
                end
                vol = vol + 4'd1;
            end else begin
                if (vol == 4'd0) begin
                    env = env & ENV_DIR_MASK;
                    return;
                end
                vol = vol - 4'd1;
            end
            env[7:4] = vol;
        endfunction

        function void step_length(logic [15:0] cyc);
            longint unsigned span;
            len_count = sat_add(len_count, cyc);
            span = 64'(LENGTH_SPAN) - 64'(len_load);
            if (len_en && 64'(len_count) * 64'd256 >= span * 64'(CLOCK_RATE))
                on = 1'b0;
        endfunction

        function void note_beat(cmd_t cmd, reg_sel_t sel, logic [7:0] data,
                                logic [15:0] cyc);
            channel_state_t s;
            if (cmd == CMD_TICK) begin
                step_envelope(cyc);
                step_length(cyc);
            end else begin
                case (sel)
                    REG_LEN_DUTY: begin
                        len_load = data[5:0];
                        duty     = data[7:6];
                    end
                    REG_ENVELOPE: env = data;
                    REG_FREQ_LO:  freq[7:0] = data;
                    default: begin
                        freq[10:8] = data[2:0];
                        len_en     = data[6];
                        if (data[7]) begin
                            on        = 1'b1;
                            len_count = '0;
                        end
                    end
                endcase
            end
            s.on     = on;
            s.volume = env[7:4];
            s.period = freq;
            s.duty   = duty;
            s.env    = env;
            expected_states.push_back(s);
        endfunction

        function void check_beat(channel_state_t got);
            channel_state_t want;
            if (expected_states.size() == 0) begin
                $error("result beat with no expected state waiting");
                failures++;
                return;
            end
            want = expected_states.pop_front();
            if (got.on !== want.on) begin
                $error("channel_on: expected %0d, got %0d", want.on, got.on);
                failures++;
            end
            if (got.volume !== want.volume) begin
                $error("volume_level: expected %0d, got %0d", want.volume, got.volume);
                failures++;
            end
            if (got.period !== want.period) begin
                $error("period_value: expected %0d, got %0d", want.period, got.period);
                failures++;
            end
            if (got.duty !== want.duty) begin
                $error("duty_code: expected %0d, got %0d", want.duty, got.duty);
                failures++;
            end
            if (got.env !== want.env) begin
                $error("envelope_byte: expected 0x%02h, got 0x%02h", want.env, got.env);
                failures++;
            end
        endfunction

        function int outstanding();
            return expected_states.size();
        endfunction
    endclass

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic        s_command       = 1'b0;
    logic [1:0]  s_reg_select    = 2'd0;
    logic [7:0]  s_write_data    = 8'd0;
    logic [15:0] s_tick_cycles   = 16'd0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic        m_channel_on;
    logic [3:0]  m_volume_level;
    logic [10:0] m_period_value;
    logic [1:0]  m_duty_code;
    logic [7:0]  m_envelope_byte;

    channel_state_board board = new();
    int          beats_sent   = 0;
    int unsigned idle_pct     = 10;
    bit          calm         = 1'b0;
    bit          hold_request = 1'b0;

    square_channel_envelope_length #(
        .CYCLES_PER_SECOND(CLOCK_RATE)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_reg_select(s_reg_select),
        .s_write_data(s_write_data),
        .s_tick_cycles(s_tick_cycles),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_channel_on(m_channel_on),
        .m_volume_level(m_volume_level),
        .m_period_value(m_period_value),
        .m_duty_code(m_duty_code),
        .m_envelope_byte(m_envelope_byte)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            board.note_beat(cmd_t'(s_command), reg_sel_t'(s_reg_select),
                            s_write_data, s_tick_cycles);
        if (aresetn && m_valid && m_ready)
            board.check_beat({m_channel_on, m_volume_level, m_period_value,
                              m_duty_code, m_envelope_byte});
    end

    initial begin
        int stall;
        int unsigned stall_pct;
        stall_pct = 15;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
                stall = $urandom_range(1, 6);
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
            if ($urandom_range(0, 63) == 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 15;
                    default: stall_pct = 40;
                endcase
            end
        end
    end

    initial begin
        int cyc;
        cyc = 0;
        while (cyc < CYCLE_LIMIT) begin
            @(posedge aclk);
            cyc++;
        end
        $display("square_channel_envelope_length verification failed");
        $finish;
    end

    task automatic send_beat(cmd_t cmd, reg_sel_t sel, logic [7:0] data,
                             logic [15:0] cyc);
        int gap;
        if (!calm && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_reg_select  <= sel;
        s_write_data  <= data;
        s_tick_cycles <= cyc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
        if (beats_sent == HOLD_AT) hold_request = 1'b1;
        if (beats_sent == CALM_AT) calm = 1'b1;
    endtask

    task automatic write_reg(reg_sel_t sel, logic [7:0] data);
        send_beat(CMD_WRITE, sel, data, 16'($urandom));
    endtask

    task automatic tick(logic [15:0] cyc);
        send_beat(CMD_TICK, reg_sel_t'($urandom_range(0, 3)), 8'($urandom), cyc);
    endtask

    function automatic logic [15:0] pick_cycles();
        case ($urandom_range(0, 3))
            0:       return 16'hFFFF;
            1:       return 16'($urandom_range(0, 255));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic run_voice_sequence();
        logic [7:0] env_byte;
        logic [7:0] hi_byte;
        int n;
        env_byte[7:3] = 5'($urandom);
        env_byte[2:0] = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                    : 3'($urandom_range(1, 2));
        hi_byte = 8'($urandom);
        if ($urandom_range(0, 9) != 0) hi_byte[7] = 1'b1;
        if ($urandom_range(0, 3) != 0) write_reg(REG_LEN_DUTY, 8'($urandom));
        write_reg(REG_ENVELOPE, env_byte);
        if ($urandom_range(0, 3) != 0) write_reg(REG_FREQ_LO, 8'($urandom));
        write_reg(REG_FREQ_HI, hi_byte);
        n = $urandom_range(4, 40);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0)
                write_reg(reg_sel_t'($urandom_range(0, 3)), 8'($urandom));
            else
                tick(pick_cycles());
        end
    endtask

    task automatic run_noise();
        int n;
        n = $urandom_range(1, 8);
        repeat (n)
            send_beat(cmd_t'($urandom_range(0, 1)), reg_sel_t'($urandom_range(0, 3)),
                      8'($urandom), 16'($urandom));
    endtask

    // Long run after one trigger, with no further trigger, so the length counter saturates.
    task automatic run_quiet_stretch();
        write_reg(REG_ENVELOPE, 8'h00);
        write_reg(REG_FREQ_HI, 8'h80 | 8'($urandom_range(0, 7)));
        repeat (300) tick(16'hFFFF);
        write_reg(REG_FREQ_HI, 8'h40);
        tick(16'd0);
    endtask

    initial begin
        bit quiet_done;
        quiet_done = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        tick(16'd0);
        write_reg(REG_LEN_DUTY, 8'hFF);
        write_reg(REG_ENVELOPE, 8'hF9);
        write_reg(REG_FREQ_LO, 8'hFF);
        write_reg(REG_FREQ_HI, 8'hC7);
        tick(16'hFFFF);
        tick(16'hFFFF);
        write_reg(REG_ENVELOPE, 8'h01);
        tick(16'hFFFF);
        tick(16'hFFFF);
        write_reg(REG_ENVELOPE, 8'h72);
        repeat (3) tick(16'hFFFF);
        write_reg(REG_ENVELOPE, 8'h00);
        tick(16'hFFFF);
        write_reg(REG_LEN_DUTY, 8'h00);
        write_reg(REG_FREQ_HI, 8'h80);
        write_reg(REG_FREQ_LO, 8'h00);
        tick(16'd1);
        write_reg(REG_FREQ_HI, 8'h47);
        tick(16'hFFFF);
        write_reg(REG_ENVELOPE, 8'h8F);
        tick(16'd0);

        while (beats_sent < TOTAL_BEATS) begin
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                default: idle_pct = 35;
            endcase
            if (!quiet_done && beats_sent >= QUIET_AT) begin
                quiet_done = 1'b1;
                run_quiet_stretch();
            end else if ($urandom_range(0, 9) < 8) begin
                run_voice_sequence();
            end else begin
                run_noise();
            end
        end
        s_valid <= 1'b0;

        while (board.outstanding() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.failures == 0)
            $display("square_channel_envelope_length verification clean");
        else
            $display("square_channel_envelope_length verification failed");
        $finish;
    end

endmodule
